>>> design/mandelbrot_pixel_escape_defines.svh
// Assertion macros shared by the escape-time pipeline modules.
`ifndef MANDELBROT_PIXEL_ESCAPE_DEFINES_SVH
`define MANDELBROT_PIXEL_ESCAPE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mbe_pkg.sv
// Types, constants and the Q4.12 multiply for the escape-time pipeline.
`default_nettype none
package mbe_pkg;

    localparam int MAX_ITER_DEF      = 20;
    localparam int CANVAS_WIDTH_DEF  = 80;
    localparam int CANVAS_HEIGHT_DEF = 56;

    localparam int CNT_W  = 8;
    localparam int ADDR_W = 11;

    localparam logic [15:0] ESCAPE_LIMIT = 16'h4000;

    localparam logic [15:0] CENTER_X_RST = 16'hF800;
    localparam logic [15:0] CENTER_Y_RST = 16'h0000;
    localparam logic [14:0] STEP_RST     = 15'd160;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_STEP     = 2'd2;

    localparam logic [1:0] PEN_BLUE  = 2'd0;
    localparam logic [1:0] PEN_WHITE = 2'd1;
    localparam logic [1:0] PEN_BLACK = 2'd2;
    localparam logic [1:0] PEN_RED   = 2'd3;

    localparam logic [CNT_W-1:0] PEN_RED_FROM   = 8'd5;
    localparam logic [CNT_W-1:0] PEN_WHITE_FROM = 8'd11;

    typedef struct packed {
        logic [6:0] column;
        logic [5:0] row;
    } t_pixel_in;

    typedef struct packed {
        logic [4:0]        iterations;
        logic [1:0]        pen;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        pixel_bits;
        logic              byte_complete;
    } t_pixel_out;

    // One pixel in flight between cells
    typedef struct packed {
        logic              valid;
        logic              done;
        logic [CNT_W-1:0]  count;
        logic [15:0]       cx;
        logic [15:0]       cy;
        logic [15:0]       zx;
        logic [15:0]       zy;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        k;
    } t_cell_bus;

    // Sign-magnitude Q4.12 multiply, magnitude truncated toward zero
    function automatic logic [15:0] q_mul(input logic [15:0] a, input logic [15:0] b);
        logic        neg;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [31:0] prod;
        logic [15:0] mag;
        neg  = a[15] ^ b[15];
        ma   = a[15] ? 16'(16'd0 - a) : a;
        mb   = b[15] ? 16'(16'd0 - b) : b;
        prod = 32'(ma) * 32'(mb);
        mag  = prod[27:12];
        return neg ? 16'(16'd0 - mag) : mag;
    endfunction

endpackage
`default_nettype wire

>>> design/mbe_cell.sv
// One escape iteration: squares and cross product, then escape test and z update.
`default_nettype none
`include "mandelbrot_pixel_escape_defines.svh"
module mbe_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire mbe_pkg::t_cell_bus i_bus,
    output mbe_pkg::t_cell_bus      o_bus
);

    mbe_pkg::t_cell_bus r_a;
    mbe_pkg::t_cell_bus r_b;
    mbe_pkg::t_cell_bus n_b;
    logic [15:0]        r_sx;
    logic [15:0]        r_sy;
    logic [15:0]        r_cross;
    logic [15:0]        sum_sq;

    always_comb begin
        sum_sq = r_sx + r_sy;
        n_b    = r_a;
        if (r_a.valid && !r_a.done) begin
            if (sum_sq >= mbe_pkg::ESCAPE_LIMIT) begin
                n_b.done = 1'b1;
            end else begin
                n_b.zy    = {r_cross[14:0], 1'b0} + r_a.cy;
                n_b.zx    = (r_sx - r_sy) + r_a.cx;
                n_b.count = r_a.count + mbe_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_a     <= i_bus;
            r_sx    <= mbe_pkg::q_mul(i_bus.zx, i_bus.zx);
            r_sy    <= mbe_pkg::q_mul(i_bus.zy, i_bus.zy);
            r_cross <= mbe_pkg::q_mul(i_bus.zx, i_bus.zy);
            r_b     <= n_b;
        end
    end

    assign o_bus = r_b;

    // an escaped pixel passes through with its count frozen
    `MPE_ASSERT_NXT(a_done_hold, i_clk, i_rst_n, i_en && r_a.valid && r_a.done, r_b.done && r_b.count == $past(r_a.count))
    // a live pixel either escapes here or gains exactly one iteration
    `MPE_ASSERT_NXT(a_count_step, i_clk, i_rst_n, i_en && r_a.valid && !r_a.done, r_b.done || r_b.count == 8'($past(r_a.count) + 8'd1))

endmodule
`default_nettype wire

>>> design/mbe_map.sv
// Maps a canvas pixel to the complex point c and its canvas byte position.
`default_nettype none
module mbe_map #(
    parameter int CANVAS_WIDTH  = mbe_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = mbe_pkg::CANVAS_HEIGHT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire mbe_pkg::t_pixel_in  i_pixel,
    input  wire logic [15:0]         i_center_x,
    input  wire logic [15:0]         i_center_y,
    input  wire logic [14:0]         i_step,
    output mbe_pkg::t_cell_bus       o_bus
);

    localparam int HALF_W      = CANVAS_WIDTH / 2;
    localparam int HALF_H      = CANVAS_HEIGHT / 2;
    localparam int BYTES_ROW   = CANVAS_WIDTH / 4;

    mbe_pkg::t_cell_bus r_bus;
    mbe_pkg::t_cell_bus n_bus;
    logic [15:0]        dx;
    logic [15:0]        dy;
    logic [15:0]        off_x;
    logic [15:0]        off_y;

    always_comb begin
        // offsets from canvas center wrap mod 2^16
        dx    = {9'd0, i_pixel.column} - 16'(HALF_W);
        dy    = {10'd0, i_pixel.row} - 16'(HALF_H);
        off_x = dx * {1'b0, i_step};
        off_y = dy * {1'b0, i_step};

        n_bus       = '0;
        n_bus.valid = i_valid;
        n_bus.cx    = i_center_x + off_x;
        n_bus.cy    = i_center_y + off_y;
        n_bus.addr  = ({5'd0, i_pixel.row} * mbe_pkg::ADDR_W'(BYTES_ROW))
                    + {6'd0, i_pixel.column[6:2]};
        n_bus.k     = i_pixel.column[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule
`default_nettype wire

>>> design/mandelbrot_pixel_escape.sv
// Top level: configuration registers, mapping stage, chain of iteration cells, result register.
`default_nettype none
`include "mandelbrot_pixel_escape_defines.svh"
// Escape-time engine for one canvas pixel per beat. A pixel enters the mapping
// stage, then walks a chain of MAX_ITER identical cells, each doing one z*z + c
// iteration over two register stages, then a result register forms pen and byte
// bits. The chain takes a new pixel every cycle while results drain. A stalled
// result freezes the whole chain, so input stall follows output stall when the
// result register is full. Configuration registers feed the mapping stage
// directly; write them only with the chain empty. Config ready is always high.
module mandelbrot_pixel_escape #(
    parameter int MAX_ITER      = mbe_pkg::MAX_ITER_DEF,
    parameter int CANVAS_WIDTH  = mbe_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = mbe_pkg::CANVAS_HEIGHT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mbe_pkg::t_pixel_in  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mbe_pkg::t_pixel_out      o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    logic [15:0]         r_center_x;
    logic [15:0]         r_center_y;
    logic [14:0]         r_step;
    logic                r_out_valid;
    mbe_pkg::t_pixel_out r_out;
    mbe_pkg::t_pixel_out n_out;
    logic                en;
    mbe_pkg::t_cell_bus  chain [MAX_ITER+1];
    mbe_pkg::t_cell_bus  last;
    logic [2:0]          hi_pos;
    logic [2:0]          lo_pos;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= mbe_pkg::CENTER_X_RST;
            r_center_y <= mbe_pkg::CENTER_Y_RST;
            r_step     <= mbe_pkg::STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbe_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                mbe_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                mbe_pkg::CFG_STEP:     r_step     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    mbe_map #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_pixel    (i_in),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_step     (r_step),
        .o_bus      (chain[0])
    );

    for (genvar g = 0; g < MAX_ITER; g++) begin : g_cell
        mbe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    assign last = chain[MAX_ITER];

    always_comb begin
        n_out = '0;
        if (last.count >= mbe_pkg::CNT_W'(MAX_ITER)) begin
            n_out.pen = mbe_pkg::PEN_BLACK;
        end else if (last.count < mbe_pkg::PEN_RED_FROM) begin
            n_out.pen = mbe_pkg::PEN_BLUE;
        end else if (last.count < mbe_pkg::PEN_WHITE_FROM) begin
            n_out.pen = mbe_pkg::PEN_RED;
        end else begin
            n_out.pen = mbe_pkg::PEN_WHITE;
        end
        // Mode-1 layout: low pen bit in the high nibble
        hi_pos = 3'd7 - {1'b0, last.k};
        lo_pos = 3'd3 - {1'b0, last.k};
        n_out.pixel_bits[hi_pos] = n_out.pen[0];
        n_out.pixel_bits[lo_pos] = n_out.pen[1];
        n_out.iterations    = last.count[4:0];
        n_out.byte_address  = last.addr;
        n_out.byte_complete = (last.k == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // input only backs up behind a held result
    `MPE_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)

endmodule
`default_nettype wire

>>> verif/tb_mandelbrot_pixel_escape.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
module tb_mandelbrot_pixel_escape;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITER_CAP   = mbe_pkg::MAX_ITER_DEF;
    localparam int GRID_COLS  = mbe_pkg::CANVAS_WIDTH_DEF;
    localparam int GRID_ROWS  = mbe_pkg::CANVAS_HEIGHT_DEF;
    localparam int PIPE_DEPTH = 2 * ITER_CAP + 2;
    localparam int HOLD_OFF   = 150;
    // index 3 decodes to no register
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [1:0]          i_cfg_index = mbe_pkg::CFG_CENTER_X;
    logic [15:0]         i_cfg_data  = 16'h0000;
    mbe_pkg::t_pixel_in  i_in        = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_cfg_ready;
    mbe_pkg::t_pixel_out o_out;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int steady   = 0;

    mandelbrot_pixel_escape uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    class escape_checker;
        logic [15:0]         center_x;
        logic [15:0]         center_y;
        logic [14:0]         step;
        mbe_pkg::t_pixel_out due_pixels[$];
        int unsigned         mismatches;

        function new();
            center_x   = 16'hF800;
            center_y   = 16'h0000;
            step       = 15'd160;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                mbe_pkg::CFG_CENTER_X: center_x = data;
                mbe_pkg::CFG_CENTER_Y: center_y = data;
                mbe_pkg::CFG_STEP:     step     = data[14:0];
                default: ;
            endcase
        endfunction

        // sign-magnitude Q4.12 product, magnitude truncated toward zero
        function logic [15:0] q412_mul(logic [15:0] a, logic [15:0] b);
            logic [15:0] ma;
            logic [15:0] mb;
            logic [31:0] prod;
            logic [15:0] mag;
            ma   = a[15] ? 16'h0000 - a : a;
            mb   = b[15] ? 16'h0000 - b : b;
            prod = ma * mb;
            mag  = prod[27:12];
            return (a[15] ^ b[15]) ? 16'h0000 - mag : mag;
        endfunction

        function logic [15:0] to_plane(logic [15:0] centre, logic [15:0] coord,
                                       logic [15:0] half);
            logic [15:0] d;
            logic [15:0] off;
            d   = coord - half;
            off = d * {1'b0, step};
            return centre + off;
        endfunction

        function void log_pixel(mbe_pkg::t_pixel_in px);
            logic [15:0]         cx;
            logic [15:0]         cy;
            logic [15:0]         zx;
            logic [15:0]         zy;
            logic [15:0]         sx;
            logic [15:0]         sy;
            logic [15:0]         mag_sum;
            logic [15:0]         zxy;
            int                  n;
            int                  k;
            bit                  escaped;
            mbe_pkg::t_pixel_out want;
            cx = to_plane(center_x, 16'(px.column), 16'(GRID_COLS / 2));
            cy = to_plane(center_y, 16'(px.row), 16'(GRID_ROWS / 2));
            zx = '0;
            zy = '0;
            n  = 0;
            escaped = 1'b0;
            while (!escaped && n < ITER_CAP) begin
                sx      = q412_mul(zx, zx);
                sy      = q412_mul(zy, zy);
                mag_sum = sx + sy;
                if (mag_sum >= mbe_pkg::ESCAPE_LIMIT) begin
                    escaped = 1'b1;
                end else begin
                    zxy = q412_mul(zx, zy);
                    zy  = zxy + zxy + cy;
                    zx  = sx - sy + cx;
                    n++;
                end
            end
            want = '0;
            want.iterations = 5'(n);
            if (n >= ITER_CAP)                    want.pen = mbe_pkg::PEN_BLACK;
            else if (n < mbe_pkg::PEN_RED_FROM)   want.pen = mbe_pkg::PEN_BLUE;
            else if (n < mbe_pkg::PEN_WHITE_FROM) want.pen = mbe_pkg::PEN_RED;
            else                                  want.pen = mbe_pkg::PEN_WHITE;
            k = px.column[1:0];
            want.byte_address  = mbe_pkg::ADDR_W'(int'(px.row) * (GRID_COLS / 4)
                                                  + int'(px.column >> 2));
            if (want.pen[0]) want.pixel_bits[7 - k] = 1'b1;
            if (want.pen[1]) want.pixel_bits[3 - k] = 1'b1;
            want.byte_complete = (k == 3);
            due_pixels.push_back(want);
        endfunction

        function void match_pixel(mbe_pkg::t_pixel_out got);
            mbe_pkg::t_pixel_out want;
            if (due_pixels.size() == 0) begin
                $error("result beat with no pixel pending: %p", got);
                mismatches++;
                return;
            end
            want = due_pixels.pop_front();
            if (got.iterations !== want.iterations) begin
                $error("iterations: expected %0d, got %0d", want.iterations, got.iterations);
                mismatches++;
            end
            if (got.pen !== want.pen) begin
                $error("pen: expected %0d, got %0d", want.pen, got.pen);
                mismatches++;
            end
            if (got.byte_address !== want.byte_address) begin
                $error("byte_address: expected %0d, got %0d",
                       want.byte_address, got.byte_address);
                mismatches++;
            end
            if (got.pixel_bits !== want.pixel_bits) begin
                $error("pixel_bits: expected %02h, got %02h", want.pixel_bits, got.pixel_bits);
                mismatches++;
            end
            if (got.byte_complete !== want.byte_complete) begin
                $error("byte_complete: expected %0d, got %0d",
                       want.byte_complete, got.byte_complete);
                mismatches++;
            end
        endfunction
    endclass

    escape_checker book = new();

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) book.match_pixel(o_out);
    end

    // result side: random stall bursts, one long hold-off on request, none at the end
    initial begin
        wait (i_rst_n);
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(20, 80)) @(posedge i_clk);
                    end
                    1: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(1, 16)) @(posedge i_clk);
                    end
                    default: begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 16)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    function automatic mbe_pkg::t_pixel_in rand_pixel();
        mbe_pkg::t_pixel_in px;
        if ($urandom_range(0, 7) == 0) begin
            px.column = 7'($urandom);
            px.row    = 6'($urandom);
        end else begin
            px.column = 7'($urandom_range(0, GRID_COLS - 1));
            px.row    = 6'($urandom_range(0, GRID_ROWS - 1));
        end
        return px;
    endfunction

    task automatic send_pixel(input mbe_pkg::t_pixel_in px);
        i_in       <= px;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.log_pixel(px);
    endtask

    // sender gaps: random idle bursts, with stretches of back-to-back beats
    task automatic pace_sender();
        if (calm) return;
        if (steady > 0) begin
            steady--;
        end else if ($urandom_range(0, 19) == 0) begin
            steady = $urandom_range(30, 80);
        end else if ($urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            i_in       <= mbe_pkg::t_pixel_in'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_at(input int col, input int row);
        mbe_pkg::t_pixel_in px;
        px.column = 7'(col);
        px.row    = 6'(row);
        send_pixel(px);
        pace_sender();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data, input bit last);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.write_reg(idx, data);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (book.due_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic set_view(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] step_data);
        wait_drained();
        write_reg(mbe_pkg::CFG_CENTER_X, cx, 1'b0);
        write_reg(mbe_pkg::CFG_CENTER_Y, cy, 1'b0);
        write_reg(CFG_SPARE, 16'($urandom), 1'b0);
        write_reg(mbe_pkg::CFG_STEP, step_data, 1'b1);
    endtask

    task automatic render(input int count);
        repeat (count) begin
            send_pixel(rand_pixel());
            pace_sender();
        end
    endtask

    task automatic near_set_view();
        set_view(16'(int'($urandom_range(0, 10240)) - 8192),
                 16'(int'($urandom_range(0, 12000)) - 6000),
                 16'($urandom_range(8, 400)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view: canvas corners, off-canvas coordinates, every column phase,
        // points inside the set, near the cusp and far outside
        send_at(0, 0);
        send_at(79, 55);
        send_at(127, 63);
        send_at(0, 63);
        send_at(127, 0);
        send_at(80, 56);
        send_at(40, 28);
        send_at(41, 28);
        send_at(42, 28);
        send_at(43, 28);
        send_at(20, 28);
        send_at(50, 28);
        send_at(57, 28);
        send_at(59, 28);
        send_at(60, 28);
        send_at(61, 28);
        send_at(62, 28);
        send_at(70, 28);
        send_at(48, 10);
        send_at(35, 16);
        send_at(38, 40);
        send_at(3, 5);
        send_at(96, 40);
        send_at(64, 32);

        // long result hold-off while pixels keep coming, so the input backs up
        set_view(16'hF800, 16'h0000, 16'd160);
        hold_req = 1'b1;
        repeat (120) send_pixel(rand_pixel());
        render(60);

        set_view(16'h7FFF, 16'h8000, 16'h7FFF);
        render(120);
        set_view(16'h8000, 16'h7FFF, 16'h0001);
        render(120);
        // bit 15 of the step write is dropped, leaving a zero step
        set_view(16'(int'($urandom_range(0, 8192)) - 6144), 16'($urandom), 16'h8000);
        render(100);
        repeat (3) begin
            near_set_view();
            render(200);
        end
        set_view(16'($urandom), 16'($urandom), 16'($urandom));
        render(120);

        calm = 1'b1;
        near_set_view();
        render(150);

        wait_drained();
        if (book.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/mbe_pkg.sv
design/mbe_cell.sv
design/mbe_map.sv
design/mandelbrot_pixel_escape.sv
verif/tb_mandelbrot_pixel_escape.sv
